### rtl/kis_pkg.sv
// Shared widths and codes for the keyframe interval search block.
// No dependencies; imported by every module of the block.
`default_nettype none

package kis_pkg;

  localparam int IDX_W   = 8;   // reported index / cursor width
  localparam int TIME_W  = 24;  // Q16.8 tick width
  localparam int COUNT_W = 9;   // key_count register width

  // input tdata layout: key_index, key_time, current_tick
  localparam int IN_KIDX_LSB = 0;
  localparam int IN_KTIM_LSB = IN_KIDX_LSB + IDX_W;
  localparam int IN_TICK_LSB = IN_KTIM_LSB + TIME_W;
  localparam int IN_TDATA_W  = IN_TICK_LSB + TIME_W;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

endpackage

`default_nettype wire

### rtl/keyframe_interval_search.sv
// Keyframe interval search: key time table, forward search cursor, fraction divider.
// Depends on kis_pkg, kis_key_ram and kis_divider.
//
// Usage:
//   Slave stream: tuser = operation (0 load, 1 query); tdata = key_index,
//   key_time, current_tick from bit 0 up. A load writes one table slot and
//   returns nothing. A query returns one master transaction with lower_index,
//   upper_index, blend_fraction (Q1.16, 65536 = 1.0). cfg_we_i/cfg_wdata_i
//   write key_count; the user must write it only while the block is idle,
//   as the block itself does not enforce this. A query whose cursor is
//   past the keys in use goes straight to its result; otherwise it reads
//   the start key and scans forward, one table read per scan step through
//   the single read port, and runs the serial divider when a pair is found.
//   s_axis_tready_o is high only while no query is in progress.
//   The result sits in an output register; a new item is accepted while it
//   waits. A finished query holds in its last state until that register is
//   free, so a stalled receiver stalls the block after one extra query.
//   Reset clears cursor, previous tick and key_count (to 1); the table is
//   not cleared and must be loaded before it is searched.
`default_nettype none

module keyframe_interval_search
  import kis_pkg::*;
#(
  parameter int MAX_KEYS      = 256,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // tdata: key_index[7:0], key_time[31:8], current_tick[55:32]
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: operation[0]
  input  wire logic                 s_axis_tuser_i,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // tdata: lower_index[7:0], upper_index[15:8], blend_fraction[FRACTION_BITS+16:16],
  // zero padded to whole bytes
  output logic [((2*IDX_W+FRACTION_BITS+1+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [COUNT_W-1:0]   cfg_wdata_i
);

  localparam int IW    = $clog2(MAX_KEYS);
  localparam int CW    = $clog2(MAX_KEYS + 1);
  localparam int SW    = (CW > IDX_W) ? CW : IDX_W;
  localparam int WW    = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int FW    = FRACTION_BITS + 1;
  localparam int OUT_W = ((2*IDX_W+FW+7)/8)*8;
  localparam logic [FW-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD_K  = 7'b0000010,
    S_LD_K  = 7'b0000100,
    S_CHK_K = 7'b0001000,
    S_CHK_N = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [COUNT_W-1:0] key_count_q;
  logic [IDX_W-1:0]   cursor_q, cursor_d;
  logic [TIME_W-1:0]  prev_q, prev_d;

  logic [SW-1:0]      idx_q, idx_d;
  logic [SW-1:0]      nxt_q, nxt_d;
  logic [SW-1:0]      n_q, n_d;
  logic [TIME_W-1:0]  tick_q, tick_d;
  logic [TIME_W-1:0]  k_q, k_d;
  logic [IDX_W-1:0]   lower_q, lower_d;
  logic [IDX_W-1:0]   upper_q, upper_d;
  logic [FW-1:0]      frac_q, frac_d;

  logic               out_valid_q, out_valid_d;
  logic [IDX_W-1:0]   out_lower_q, out_lower_d;
  logic [IDX_W-1:0]   out_upper_q, out_upper_d;
  logic [FW-1:0]      out_frac_q, out_frac_d;

  // input fields
  op_e                in_op;
  logic [IDX_W-1:0]   in_kidx;
  logic [TIME_W-1:0]  in_ktime;
  logic [TIME_W-1:0]  in_tick;
  logic               in_fire;

  assign in_op    = op_e'(s_axis_tuser_i);
  assign in_kidx  = s_axis_tdata_i[IN_KIDX_LSB +: IDX_W];
  assign in_ktime = s_axis_tdata_i[IN_KTIM_LSB +: TIME_W];
  assign in_tick  = s_axis_tdata_i[IN_TICK_LSB +: TIME_W];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;

  // keys in use: zero counts as one, saturated at the table depth
  logic [WW-1:0] kc_ext;
  logic [SW-1:0] n_use;
  always_comb begin
    kc_ext = WW'(key_count_q);
    if (kc_ext == '0) begin
      n_use = SW'(1);
    end else if (kc_ext > WW'(MAX_KEYS)) begin
      n_use = SW'(MAX_KEYS);
    end else begin
      n_use = SW'(kc_ext);
    end
  end

  // table
  logic [SW-1:0]     slot_ext;
  logic              ram_we;
  logic              ram_re;
  logic [IW-1:0]     ram_raddr;
  logic [TIME_W-1:0] ram_rdata;
  logic [SW-1:0]     idx_inc;
  logic [SW-1:0]     nxt_idx;

  assign slot_ext = SW'(in_kidx);
  assign ram_we   = in_fire && (in_op == OP_LOAD) && (slot_ext < SW'(MAX_KEYS));
  assign idx_inc  = idx_q + SW'(1);
  assign nxt_idx  = (idx_inc >= n_q) ? (n_q - SW'(1)) : idx_inc;
  assign ram_re   = (state_q == S_RD_K) || (state_q == S_CHK_K);
  assign ram_raddr = (state_q == S_CHK_K) ? nxt_idx[IW-1:0] : idx_q[IW-1:0];

  kis_key_ram #(
    .DEPTH (MAX_KEYS),
    .AW    (IW)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_ext[IW-1:0]),
    .wdata_i (in_ktime),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // fraction divider
  logic                     div_start;
  logic                     div_done;
  logic [FRACTION_BITS-1:0] div_quo;
  logic                     pair_hit;

  assign pair_hit  = (k_q <= tick_q) && (ram_rdata > tick_q);
  assign div_start = (state_q == S_CHK_N) && pair_hit;

  kis_divider #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tick_q - k_q),
    .divisor_i  (ram_rdata - k_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // sequencer
  logic [IDX_W-1:0] start_idx;
  logic             out_free;

  assign start_idx = (in_tick < prev_q) ? '0 : cursor_q;
  assign out_free  = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    prev_d      = prev_q;
    idx_d       = idx_q;
    nxt_d       = nxt_q;
    n_d         = n_q;
    tick_d      = tick_q;
    k_d         = k_q;
    lower_d     = lower_q;
    upper_d     = upper_q;
    frac_d      = frac_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_lower_d = out_lower_q;
    out_upper_d = out_upper_q;
    out_frac_d  = out_frac_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (in_op == OP_QUERY)) begin
          cursor_d = start_idx;
          prev_d   = in_tick;
          tick_d   = in_tick;
          idx_d    = SW'(start_idx);
          n_d      = n_use;
          lower_d  = start_idx;
          upper_d  = start_idx;
          frac_d   = '0;
          state_d  = (SW'(start_idx) >= n_use) ? S_FIN : S_RD_K;
        end
      end
      S_RD_K: begin
        state_d = S_LD_K;
      end
      S_LD_K: begin
        k_d     = ram_rdata;
        state_d = S_CHK_K;
      end
      S_CHK_K: begin
        if ((idx_inc == n_q) && (k_q <= tick_q)) begin
          // last key reached and passed
          lower_d = idx_q[IDX_W-1:0];
          upper_d = idx_q[IDX_W-1:0];
          frac_d  = FRAC_ONE;
          state_d = S_FIN;
        end else begin
          nxt_d   = nxt_idx;
          state_d = S_CHK_N;
        end
      end
      S_CHK_N: begin
        if (pair_hit) begin
          lower_d = idx_q[IDX_W-1:0];
          upper_d = nxt_q[IDX_W-1:0];
          state_d = S_DIV;
        end else begin
          idx_d = idx_inc;
          if (idx_inc >= n_q) begin
            state_d = S_FIN;
          end else begin
            k_d     = ram_rdata;
            state_d = S_CHK_K;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          frac_d  = {1'b0, div_quo};
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cursor_d    = lower_q;
          out_valid_d = 1'b1;
          out_lower_d = lower_q;
          out_upper_d = upper_q;
          out_frac_d  = frac_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_count_q <= COUNT_W'(1);
      cursor_q    <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        key_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    nxt_q       <= nxt_d;
    n_q         <= n_d;
    tick_q      <= tick_d;
    k_q         <= k_d;
    lower_q     <= lower_d;
    upper_q     <= upper_d;
    frac_q      <= frac_d;
    out_lower_q <= out_lower_d;
    out_upper_q <= out_upper_d;
    out_frac_q  <= out_frac_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({out_frac_q, out_upper_q, out_lower_q});

`ifndef ASSERT_OFF
  a_full_frac_same_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_frac_q == FRAC_ONE)) |-> (out_lower_q == out_upper_q))
    else $error("full fraction with distinct keys");

  a_pair_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_lower_q != out_upper_q)) |->
      (out_upper_q == out_lower_q + IDX_W'(1)))
    else $error("bracketing keys not adjacent");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_frac_q <= FRAC_ONE))
    else $error("fraction above one");

  a_cursor_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == S_FIN && state_q == S_IDLE) |-> (cursor_q == out_lower_q))
    else $error("cursor not moved to reported lower index");
`endif

endmodule

`default_nettype wire

### rtl/kis_key_ram.sv
// Key time table: one write port, one registered read port.
// Depends on kis_pkg for the time width.
`default_nettype none

module kis_key_ram
  import kis_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [TIME_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [TIME_W-1:0] rdata_o
);

  logic [TIME_W-1:0] mem [DEPTH];
  logic [TIME_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/kis_divider.sv
// Restoring divider producing the fraction bits, one quotient bit per cycle.
// Requires dividend < divisor. Depends on kis_pkg for the time width.
`default_nettype none

module kis_divider
  import kis_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [TIME_W-1:0]        dividend_i,
  input  wire logic [TIME_W-1:0]        divisor_i,
  output logic                          done_o,
  output logic [FRACTION_BITS-1:0]      quotient_o
);

  localparam int CNT_W = $clog2(FRACTION_BITS);

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [TIME_W-1:0]        rem_q, rem_d;
  logic [TIME_W-1:0]        den_q, den_d;
  logic [FRACTION_BITS-1:0] quo_q, quo_d;

  logic [TIME_W:0] rem_shl;
  logic [TIME_W:0] rem_sub;
  logic            fits;

  // remainder stays below the divisor, so the shifted value fits in one extra bit
  assign rem_shl = {rem_q, 1'b0};
  assign rem_sub = rem_shl - {1'b0, den_q};
  assign fits    = (rem_shl >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[TIME_W-1:0] : rem_shl[TIME_W-1:0];
      quo_d = {quo_q[FRACTION_BITS-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(FRACTION_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### tb/sv/kis_checker.sv
// Result checker for keyframe_interval_search: watches the input, result and register ports,
// predicts each query's bracket and compares it field by field. Depends on kis_pkg.
module kis_checker
  import kis_pkg::*;
#(
  parameter int MAX_KEYS      = 256,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tdata: key_index, key_time, current_tick; tuser: operation
  input  logic [IN_TDATA_W-1:0] s_tdata_i,
  input  logic                  s_tuser_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  // tdata: lower_index, upper_index, blend_fraction, zero padding
  input  logic [((2*IDX_W+FRACTION_BITS+1+7)/8)*8-1:0] m_tdata_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic                  cfg_we_i,
  input  logic [COUNT_W-1:0]    cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OUT_W   = ((2*IDX_W+FRACTION_BITS+1+7)/8)*8;
  localparam int FRAC_LSB = 2*IDX_W;
  localparam int PAD_LSB  = 2*IDX_W + FRACTION_BITS + 1;

  typedef struct packed {
    logic [IDX_W-1:0]       lower;
    logic [IDX_W-1:0]       upper;
    logic [FRACTION_BITS:0] frac;
  } bracket_t;

  logic [TIME_W-1:0]  key_tbl [MAX_KEYS];
  logic [IDX_W-1:0]   cursor;
  logic [TIME_W-1:0]  last_tick;
  logic [COUNT_W-1:0] key_count;
  bracket_t           bracket_q[$];

  initial begin
    for (int j = 0; j < MAX_KEYS; j++) key_tbl[j] = '0;
  end

  // Scan forward from the cursor for the key pair around the tick.
  task automatic search_bracket(input logic [TIME_W-1:0] tick, output bracket_t res);
    int unsigned       n, i, nx, lo, up;
    logic [TIME_W-1:0] k, kn, diff, span;
    longint unsigned   num, den, fr;
    if (tick < last_tick) begin
      cursor    = '0;
      last_tick = '0;
    end
    n  = (key_count == 0) ? 1 : ((key_count > MAX_KEYS) ? MAX_KEYS : key_count);
    lo = cursor;
    up = cursor;
    fr = 0;
    for (i = cursor; i < n; i++) begin
      k = key_tbl[i];
      if (i == n - 1 && k <= tick) begin
        lo = i;
        up = i;
        fr = 64'd1 << FRACTION_BITS;
        break;
      end
      nx = (i + 1 >= n) ? n - 1 : i + 1;
      kn = key_tbl[nx];
      if (k <= tick && kn > tick) begin
        diff = tick - k;
        span = kn - k;
        num  = diff;
        den  = span;
        lo   = i;
        up   = nx;
        fr   = (num << FRACTION_BITS) / den;
        break;
      end
    end
    cursor    = lo[IDX_W-1:0];
    last_tick = tick;
    res.lower = lo[IDX_W-1:0];
    res.upper = up[IDX_W-1:0];
    res.frac  = fr[FRACTION_BITS:0];
  endtask

  // Append one predicted bracket behind the ones still outstanding.
  function automatic void add_expected(input bracket_t b);
    bracket_q.insert(bracket_q.size(), b);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bracket_t          want, got;
    logic [OUT_W-PAD_LSB-1:0] pad;
    logic [IDX_W-1:0]  slot;
    logic [TIME_W-1:0] ktime, tick;
    if (!rst_ni) begin
      cursor       = '0;
      last_tick    = '0;
      key_count    = COUNT_W'(1);
      bracket_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      // results first: a result never belongs to an input taken at the same edge
      if (m_tvalid_i && m_tready_i) begin
        got.lower = m_tdata_i[IDX_W-1:0];
        got.upper = m_tdata_i[2*IDX_W-1:IDX_W];
        got.frac  = m_tdata_i[FRAC_LSB +: FRACTION_BITS+1];
        pad       = m_tdata_i[OUT_W-1:PAD_LSB];
        if (bracket_q.size() == 0) begin
          $display("%0t: result with nothing expected: lower %0d upper %0d fraction %0d",
                   $time, got.lower, got.upper, got.frac);
          fail_count_o++;
        end else begin
          want = bracket_q.pop_front();
          if (got.lower !== want.lower) begin
            $display("%0t: lower_index expected %0d actual %0d", $time, want.lower, got.lower);
            fail_count_o++;
          end
          if (got.upper !== want.upper) begin
            $display("%0t: upper_index expected %0d actual %0d", $time, want.upper, got.upper);
            fail_count_o++;
          end
          if (got.frac !== want.frac) begin
            $display("%0t: blend_fraction expected %0d actual %0d", $time, want.frac, got.frac);
            fail_count_o++;
          end
          if (pad !== '0) begin
            $display("%0t: tdata padding expected 0 actual %0h", $time, pad);
            fail_count_o++;
          end
          checked_o++;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        slot  = s_tdata_i[IN_KIDX_LSB +: IDX_W];
        ktime = s_tdata_i[IN_KTIM_LSB +: TIME_W];
        tick  = s_tdata_i[IN_TICK_LSB +: TIME_W];
        if (s_tuser_i == OP_LOAD) begin
          if (slot < MAX_KEYS) key_tbl[slot] = ktime;
        end else begin
          search_bracket(tick, want);
          add_expected(want);
        end
      end
      if (cfg_we_i) key_count = cfg_wdata_i;
      pending_o = bracket_q.size();
    end
  end

endmodule

### tb/sv/tb_top.sv
// Top of the keyframe_interval_search testbench: clock, reset, load and query traffic,
// random receiver stalls and the verdict. Depends on kis_pkg, the block and kis_checker.
module tb_top;
  import kis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_KEYS      = 256;
  localparam int FRACTION_BITS = 16;
  localparam int OUT_W         = ((2*IDX_W+FRACTION_BITS+1+7)/8)*8;
  localparam int ITEMS         = 1550;
  localparam int HOLD_CYCLES   = 400;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic [IN_TDATA_W-1:0] s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  s_tvalid  = 1'b0;
  logic                  m_tready  = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [COUNT_W-1:0]    cfg_wdata = '0;
  logic                  s_tready;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tvalid;
  logic                  s_fire    = 1'b0;
  int                    fail_count, pending, checked;

  // local copy of the table, used only to aim the query ticks
  int unsigned tbl [MAX_KEYS];
  int unsigned eff_keys = 1;
  int unsigned walk, last_q;
  int unsigned loads_sent, queries_sent, settings_run, hold_asked, hold_served;
  int unsigned count_lo = 511, count_hi = 0;
  bit          no_gap;

  keyframe_interval_search #(
    .MAX_KEYS     (MAX_KEYS),
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  kis_checker #(
    .MAX_KEYS     (MAX_KEYS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .m_tdata_i   (m_tdata),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // seen at the next falling edge: was the input transaction taken
  always @(posedge clk) s_fire <= s_tvalid && s_tready;

  function automatic logic [TIME_W-1:0] rand24();
    logic [31:0] v;
    v = $urandom;
    return v[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] sat24(longint unsigned v);
    return (v > 64'hFFFFFF) ? 24'hFFFFFF : v[TIME_W-1:0];
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input op_e op, input logic [IDX_W-1:0] slot,
                           input logic [TIME_W-1:0] ktime, input logic [TIME_W-1:0] tick);
    int unsigned gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {tick, ktime, slot};
    do @(negedge clk); while (!s_fire);
    if (op == OP_LOAD) loads_sent++;
    else begin
      queries_sent++;
      last_q = tick;
    end
  endtask

  task automatic send_load(input int unsigned slot, input logic [TIME_W-1:0] t);
    tbl[slot] = t;
    send_item(OP_LOAD, slot[IDX_W-1:0], t, rand24());
  endtask

  task automatic send_query(input logic [TIME_W-1:0] tick);
    logic [31:0] v;
    v = $urandom;
    send_item(OP_QUERY, v[IDX_W-1:0], rand24(), tick);
  endtask

  task automatic wait_results_idle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_key_count(input logic [COUNT_W-1:0] v);
    wait_results_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    eff_keys = (v == 0) ? 1 : ((v > MAX_KEYS) ? MAX_KEYS : v);
    if (v < count_lo) count_lo = v;
    if (v > count_hi) count_hi = v;
    settings_run++;
  endtask

  // Next tick of a forward walk through the table; wraps to the start after the end.
  function automatic logic [TIME_W-1:0] walk_tick();
    int unsigned     lo, hi;
    longint unsigned c;
    walk += $urandom_range(0, 2);
    if (walk >= eff_keys - 1) begin
      walk = 0;
      c = longint'(tbl[eff_keys-1]) + $urandom_range(0, 'h400);
    end else begin
      lo = tbl[walk];
      hi = tbl[walk+1];
      c = (hi > lo) ? lo + $urandom_range(0, hi - lo - 1) : lo;
      if (c < last_q && last_q < hi) c = last_q;
    end
    return sat24(c);
  endfunction

  task automatic run_phase(input logic [COUNT_W-1:0] count_val, input bit hold);
    int unsigned     nq, r, j, step;
    longint unsigned t;
    write_key_count(count_val);
    no_gap = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 6) == 0) begin
      // unordered table
      for (j = 0; j < eff_keys; j++) send_load(j, rand24());
    end else begin
      t = $urandom_range(0, 'h800);
      for (j = 0; j < eff_keys; j++) begin
        send_load(j, sat24(t));
        r = $urandom_range(0, 19);
        if (r == 0) step = 0;
        else if (r < 3) step = $urandom_range(1, 8);
        else if (r < 18) step = $urandom_range('h10, 'h8000);
        else step = $urandom_range('h8000, 'h100000);
        t += step;
      end
    end
    walk = 0;
    if (hold) hold_asked++;
    nq = (eff_keys > 64) ? 40 : $urandom_range(20, 60);
    repeat (nq) begin
      r = $urandom_range(0, 99);
      if (r < 68) send_query(walk_tick());
      else if (r < 80) send_query(rand24());
      else if (r < 88) begin
        j = $urandom_range(0, eff_keys - 1);
        case ($urandom_range(0, 2))
          0:       send_query(sat24(tbl[j]));
          1:       send_query(sat24((tbl[0] > 0) ? tbl[0] - 1 : 0));
          default: send_query(sat24(longint'(tbl[eff_keys-1]) + $urandom_range(0, 'h40)));
        endcase
      end else send_load($urandom_range(0, MAX_KEYS - 1), rand24());
    end
  endtask

  function automatic logic [COUNT_W-1:0] pick_key_count(input int unsigned p);
    int unsigned r;
    case (p)
      0: return 9'd256;
      1: return 9'd0;    // treated as one key
      2: return 9'd2;
      3: return 9'd511;  // saturates to the table size
      4: return 9'd1;
      5: return 9'd16;
      default: begin
        r = $urandom_range(0, 99);
        if (r < 70) return COUNT_W'($urandom_range(2, 12));
        if (r < 92) return COUNT_W'($urandom_range(13, 48));
        return 9'd1;
      end
    endcase
  endfunction

  task automatic directed_items();
    // single key: below it, then on it
    send_load(0, 24'h000100);
    send_query(24'h000050);
    send_query(24'h000100);
    write_key_count(9'd8);
    // lowest and highest times, plus a repeated key time
    send_load(0, 24'h000000);
    send_load(1, 24'h000100);
    send_load(2, 24'h000300);
    send_load(3, 24'h001000);
    send_load(4, 24'h001001);
    send_load(5, 24'h001001);
    send_load(6, 24'h008000);
    send_load(7, 24'hFFFFFF);
    send_query(24'h000200);
    send_query(24'h001001);
    send_query(24'hFFFFFF);   // on the last key
    send_query(24'h000000);   // backward: cursor restarts
    send_query(24'h00C000);
    // shrink the table under the cursor: nothing to scan
    write_key_count(9'd3);
    send_query(24'h00D000);
    send_query(24'h000150);
    send_load(255, 24'hFFFFFF);
  endtask

  initial begin : stimulus
    int unsigned p;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    directed_items();
    p = 0;
    while (loads_sent + queries_sent < ITEMS) begin
      run_phase(pick_key_count(p), (p == 2) || (p % 12 == 7));
      p++;
    end
    wait_results_idle();
    repeat (600) @(negedge clk);
    $display("Covered %0d loads and %0d queries over %0d key count settings (%0d to %0d).",
             loads_sent, queries_sent, settings_run, count_lo, count_hi);
    $display("%0d results compared, %0d long receiver holds.", checked, hold_served);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : result_ready
    int unsigned stall_left, free_left, r;
    stall_left = 0;
    free_left  = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_served != hold_asked) begin
        hold_served++;
        stall_left = HOLD_CYCLES;
        free_left  = 0;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (free_left > 0) begin
        m_tready <= 1'b1;
        free_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) free_left = $urandom_range(1, 40);
        else if (r < 92) stall_left = $urandom_range(1, 3);
        else stall_left = $urandom_range(10, 60);
        m_tready <= (r < 55);
      end
    end
  end

  initial begin : watchdog
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### keyframe_interval_search.f
rtl/kis_pkg.sv
rtl/kis_key_ram.sv
rtl/kis_divider.sv
rtl/keyframe_interval_search.sv
tb/sv/kis_checker.sv
tb/sv/tb_top.sv
